@@ design/hoare_quicksort_macros.svh @@
// ---------------------------------------------------------------------------
// hoare_quicksort assertion macros
// shared concurrent assertion forms for the sorter checker
// ---------------------------------------------------------------------------
`ifndef HOARE_QUICKSORT_MACROS_SVH
`define HOARE_QUICKSORT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hq assertion failed");

// consequent checked in the cycle after the antecedent
`define HQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hq assertion failed");

`endif

@@ design/hq_pkg.sv @@
// ---------------------------------------------------------------------------
// hq_pkg
// shared types for the quicksort block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hq_pkg;

   localparam int VALUE_W = 32;

   // element value, signed two's complement
   typedef logic signed [VALUE_W-1:0] value_type;

   // range stack control from the sequencer
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

@@ design/hq_channels.sv @@
// ---------------------------------------------------------------------------
// hq channel interfaces
// valid/ready channels for element requests and sorted results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hq_req_if;
   logic              valid;
   logic              ready;
   hq_pkg::value_type elem_value;
   logic              is_last;

   modport source (output valid, output elem_value, output is_last, input ready);
   modport sink   (input valid, input elem_value, input is_last, output ready);
endinterface

interface hq_rsp_if;
   logic              valid;
   logic              ready;
   hq_pkg::value_type sorted_value;
   logic              is_final;
   logic              overflowed;

   modport source (output valid, output sorted_value, output is_final,
                   output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input is_final,
                   input overflowed, output ready);
endinterface

@@ design/hoare_quicksort.sv @@
// ---------------------------------------------------------------------------
// hoare_quicksort
// collects signed elements until one marked last, sorts them ascending by
// quicksort with first-element pivot and hoare partitioning, then emits them
// ---------------------------------------------------------------------------
//  channel  dir  fields                                   role
//  req_if   in   elem_value, is_last                      element request
//  rsp_if   out  sorted_value, is_final, overflowed       sorted result
//
//  loading: one cycle per request; requests past MAX_ELEMS are dropped
//  sort: each pointer compare reads over the single store port and then
//  compares; a swap adds a write state, and each range passes through pop,
//  pivot fetch and pushes; presorted input is the worst case
//  output: each result is read, loaded, then held over rsp stalls; the block
//  takes no request from the last request until the final result is taken
//  synchronous reset clears the sequencer, element count, overflow flag and stack pointer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hoare_quicksort #(
   parameter int MAX_ELEMS = 64
) (
   input  logic            clock,
   input  logic            reset,
   hq_req_if.sink          req_if,
   hq_rsp_if.source        rsp_if
);

   localparam int IdxW = $clog2(MAX_ELEMS);
   localparam int CntW = $clog2(MAX_ELEMS + 1);

   // sequencer codes
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_POP      = 4'd1;
   localparam logic [3:0] S_POP_WAIT = 4'd2;
   localparam logic [3:0] S_PIV_RD   = 4'd3;
   localparam logic [3:0] S_PIV_WAIT = 4'd4;
   localparam logic [3:0] S_RD_I     = 4'd5;
   localparam logic [3:0] S_CMP_I    = 4'd6;
   localparam logic [3:0] S_RD_J     = 4'd7;
   localparam logic [3:0] S_CMP_J    = 4'd8;
   localparam logic [3:0] S_SWAP     = 4'd9;
   localparam logic [3:0] S_SPLIT    = 4'd10;
   localparam logic [3:0] S_PUSH2    = 4'd11;
   localparam logic [3:0] S_OUT_RD   = 4'd12;
   localparam logic [3:0] S_OUT_LD   = 4'd13;
   localparam logic [3:0] S_OUT_WAIT = 4'd14;

   logic [3:0]            state_ff, state_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  overflow_ff, overflow_in;
   logic [IdxW-1:0]       lo_ff, lo_in;
   logic [IdxW-1:0]       hi_ff, hi_in;
   logic [IdxW-1:0]       i_ff, i_in;
   logic [IdxW-1:0]       j_ff, j_in;
   logic [IdxW-1:0]       k_ff, k_in;
   logic [IdxW-1:0]       sec_lo_ff, sec_lo_in;
   logic [IdxW-1:0]       sec_hi_ff, sec_hi_in;
   hq_pkg::value_type     pivot_ff, pivot_in;
   hq_pkg::value_type     vi_ff, vi_in;
   hq_pkg::value_type     out_value_ff, out_value_in;
   logic                  out_final_ff, out_final_in;
   logic                  out_ovf_ff, out_ovf_in;

   // element store
   hq_pkg::value_type     store_mem [MAX_ELEMS];
   hq_pkg::value_type     store_rd_ff;
   logic                  store_we_c;
   logic [IdxW-1:0]       store_waddr_c;
   hq_pkg::value_type     store_wdata_c;
   logic [IdxW-1:0]       store_raddr_c;

   // range stack
   hq_pkg::stack_ctl_type stack_ctl_c;
   logic [IdxW-1:0]       push_lo_c, push_hi_c;
   logic [IdxW-1:0]       pop_lo, pop_hi;
   logic                  stack_empty;

   // split point and subrange sizes
   logic [IdxW-1:0]       p_c, p1_c, left_c, right_c, last_idx_c;

   assign p_c        = (j_ff >= hi_ff) ? (hi_ff - IdxW'(1)) : j_ff;
   assign p1_c       = p_c + IdxW'(1);
   assign left_c     = p_c - lo_ff;
   assign right_c    = hi_ff - p1_c;
   assign last_idx_c = IdxW'(count_ff - CntW'(1));

   hq_range_stack #(
      .DEPTH (MAX_ELEMS),
      .IDX_W (IdxW)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .ctl     (stack_ctl_c),
      .push_lo (push_lo_c),
      .push_hi (push_hi_c),
      .pop_lo  (pop_lo),
      .pop_hi  (pop_hi),
      .empty   (stack_empty)
   );

   // channel outputs
   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = (state_ff == S_OUT_WAIT);
   assign rsp_if.sorted_value = out_value_ff;
   assign rsp_if.is_final     = out_final_ff;
   assign rsp_if.overflowed   = out_ovf_ff;

   // sequencer: load, partition loop over the shared store port, output
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      sec_lo_in     = sec_lo_ff;
      sec_hi_in     = sec_hi_ff;
      pivot_in      = pivot_ff;
      vi_in         = vi_ff;
      out_value_in  = out_value_ff;
      out_final_in  = out_final_ff;
      out_ovf_in    = out_ovf_ff;
      store_we_c    = 1'b0;
      store_waddr_c = i_ff;
      store_wdata_c = store_rd_ff;
      store_raddr_c = i_ff;
      stack_ctl_c   = '0;
      push_lo_c     = lo_ff;
      push_hi_c     = p_c;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               if (count_ff < CntW'(MAX_ELEMS)) begin
                  store_we_c    = 1'b1;
                  store_waddr_c = count_ff[IdxW-1:0];
                  store_wdata_c = req_if.elem_value;
                  count_in      = count_ff + CntW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_if.is_last) begin
                  k_in = '0;
                  if (count_in >= CntW'(2)) begin
                     stack_ctl_c.push = 1'b1;
                     push_lo_c        = '0;
                     push_hi_c        = IdxW'(count_in - CntW'(1));
                     state_in         = S_POP;
                  end else begin
                     state_in = S_OUT_RD;
                  end
               end
            end
         end
         S_POP: begin
            if (stack_empty) begin
               k_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               stack_ctl_c.pop = 1'b1;
               state_in        = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            lo_in    = pop_lo;
            hi_in    = pop_hi;
            i_in     = pop_lo;
            j_in     = pop_hi;
            state_in = (pop_lo < pop_hi) ? S_PIV_RD : S_POP;
         end
         S_PIV_RD: begin
            store_raddr_c = lo_ff;
            state_in      = S_PIV_WAIT;
         end
         S_PIV_WAIT: begin
            pivot_in = store_rd_ff;
            state_in = S_RD_I;
         end
         S_RD_I: begin
            store_raddr_c = i_ff;
            state_in      = S_CMP_I;
         end
         S_CMP_I: begin
            if (i_ff < hi_ff && store_rd_ff < pivot_ff) begin
               i_in     = i_ff + IdxW'(1);
               state_in = S_RD_I;
            end else begin
               vi_in    = store_rd_ff;
               state_in = S_RD_J;
            end
         end
         S_RD_J: begin
            store_raddr_c = j_ff;
            state_in      = S_CMP_J;
         end
         S_CMP_J: begin
            if (j_ff > lo_ff && store_rd_ff > pivot_ff) begin
               j_in     = j_ff - IdxW'(1);
               state_in = S_RD_J;
            end else if (i_ff >= j_ff) begin
               state_in = S_SPLIT;
            end else begin
               // first half of the swap: right value goes to the left slot
               store_we_c    = 1'b1;
               store_waddr_c = i_ff;
               store_wdata_c = store_rd_ff;
               state_in      = S_SWAP;
            end
         end
         S_SWAP: begin
            store_we_c    = 1'b1;
            store_waddr_c = j_ff;
            store_wdata_c = vi_ff;
            i_in          = i_ff + IdxW'(1);
            j_in          = j_ff - IdxW'(1);
            state_in      = S_RD_I;
         end
         S_SPLIT: begin
            // larger subrange goes on the stack first
            if (left_c >= right_c) begin
               stack_ctl_c.push = (lo_ff < p_c);
               push_lo_c        = lo_ff;
               push_hi_c        = p_c;
               sec_lo_in        = p1_c;
               sec_hi_in        = hi_ff;
            end else begin
               stack_ctl_c.push = (p1_c < hi_ff);
               push_lo_c        = p1_c;
               push_hi_c        = hi_ff;
               sec_lo_in        = lo_ff;
               sec_hi_in        = p_c;
            end
            state_in = S_PUSH2;
         end
         S_PUSH2: begin
            stack_ctl_c.push = (sec_lo_ff < sec_hi_ff);
            push_lo_c        = sec_lo_ff;
            push_hi_c        = sec_hi_ff;
            state_in         = S_POP;
         end
         S_OUT_RD: begin
            store_raddr_c = k_ff;
            state_in      = S_OUT_LD;
         end
         S_OUT_LD: begin
            out_value_in = store_rd_ff;
            out_final_in = (k_ff == last_idx_c);
            out_ovf_in   = overflow_ff;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_if.ready) begin
               if (out_final_ff) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = S_IDLE;
               end else begin
                  k_in     = k_ff + IdxW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      sec_lo_ff    <= sec_lo_in;
      sec_hi_ff    <= sec_hi_in;
      pivot_ff     <= pivot_in;
      vi_ff        <= vi_in;
      out_value_ff <= out_value_in;
      out_final_ff <= out_final_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // element store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (store_we_c) begin
         store_mem[store_waddr_c] <= store_wdata_c;
      end
      store_rd_ff <= store_mem[store_raddr_c];
   end

endmodule

@@ design/hq_range_stack.sv @@
// ---------------------------------------------------------------------------
// hq_range_stack
// stack of pending index ranges, one push or one pop per cycle,
// popped range available in the cycle after the pop
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hq_range_stack #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hq_pkg::stack_ctl_type ctl,
   input  logic [IDX_W-1:0]      push_lo,
   input  logic [IDX_W-1:0]      push_hi,
   output logic [IDX_W-1:0]      pop_lo,
   output logic [IDX_W-1:0]      pop_hi,
   output logic                  empty
);

   localparam int SpW   = $clog2(DEPTH + 1);
   localparam int AddrW = $clog2(DEPTH);

   logic [2*IDX_W-1:0] stack_mem [DEPTH];
   logic [2*IDX_W-1:0] rd_ff;
   logic [SpW-1:0]     sp_ff;
   logic [SpW-1:0]     sp_in;
   logic [SpW-1:0]     sp_dec_c;
   logic               full_c;

   assign sp_dec_c = sp_ff - SpW'(1);
   assign full_c   = (sp_ff == SpW'(DEPTH));
   assign empty    = (sp_ff == '0);
   assign pop_lo   = rd_ff[IDX_W-1:0];
   assign pop_hi   = rd_ff[2*IDX_W-1:IDX_W];

   // pointer update, a push onto a full stack is dropped
   always_comb begin
      sp_in = sp_ff;
      if (ctl.push && !full_c) begin
         sp_in = sp_ff + SpW'(1);
      end else if (ctl.pop && !empty) begin
         sp_in = sp_dec_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // range storage, registered read of the top entry
   always_ff @(posedge clock) begin
      if (ctl.push && !full_c) begin
         stack_mem[sp_ff[AddrW-1:0]] <= {push_hi, push_lo};
      end
      rd_ff <= stack_mem[sp_dec_c[AddrW-1:0]];
   end

endmodule

@@ design/hq_checker.sv @@
// ---------------------------------------------------------------------------
// hq_checker
// port-level checks on the quicksort block, bound into hoare_quicksort
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hoare_quicksort_macros.svh"

module hq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_is_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hq_pkg::value_type rsp_sorted_value,
   input logic              rsp_is_final,
   input logic              rsp_overflowed
);

   logic [hq_pkg::VALUE_W+1:0] rsp_payload_c;

   assign rsp_payload_c = {rsp_sorted_value, rsp_is_final, rsp_overflowed};

   // a stalled result stays offered
   `HQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled result keeps its payload
   `HQ_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload_c))

   // loading and emitting never overlap
   `HQ_ASSERT_NOW(a_one_side, clock, reset, 1'b1, !(req_ready && rsp_valid))

   // a last request closes the set until its results are out
   `HQ_ASSERT_NEXT(a_last_busy, clock, reset, req_valid && req_ready && req_is_last, !req_ready)

   // taking the final result reopens the request side
   `HQ_ASSERT_NEXT(a_final_idle, clock, reset, rsp_valid && rsp_ready && rsp_is_final, req_ready && !rsp_valid)

endmodule

bind hoare_quicksort hq_checker u_hq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_is_last      (req_if.is_last),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_sorted_value (rsp_if.sorted_value),
   .rsp_is_final     (rsp_if.is_final),
   .rsp_overflowed   (rsp_if.overflowed)
);
